// ===== rtl/oppe_pkg.sv =====
package oppe_pkg;

    typedef struct packed {
        logic [31:0] price;
        logic        last_step;
        logic        clear_totals;
    } t_in_item;

    typedef struct packed {
        logic [41:0] path_payoff;
        logic [10:0] path_entries;
        logic [62:0] total_payoff;
        logic [39:0] total_entries;
    } t_out_item;

    localparam logic [2:0] CFG_KIND    = 3'd0;
    localparam logic [2:0] CFG_STYLE   = 3'd1;
    localparam logic [2:0] CFG_MODE    = 3'd2;
    localparam logic [2:0] CFG_STRIKE  = 3'd3;
    localparam logic [2:0] CFG_BARRIER = 3'd4;
    localparam logic [2:0] CFG_DISC    = 3'd5;

    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_AS_FP = 3'd1;
    localparam logic [2:0] MODE_AS_FS = 3'd2;
    localparam logic [2:0] MODE_BA_UI = 3'd3;
    localparam logic [2:0] MODE_BA_UO = 3'd4;
    localparam logic [2:0] MODE_BA_DI = 3'd5;
    localparam logic [2:0] MODE_BA_DO = 3'd6;

    localparam logic STYLE_EU = 1'b0;
    localparam logic STYLE_AM = 1'b1;

    localparam logic KIND_CALL = 1'b0;
    localparam logic KIND_PUT  = 1'b1;

    localparam logic [41:0] M42 = {42{1'b1}};
    localparam logic [62:0] M63 = {63{1'b1}};
    localparam logic [39:0] M40 = {40{1'b1}};
    localparam logic [31:0] ONE_Q131 = 32'h8000_0000;

endpackage

// ===== rtl/oppe_divider.sv =====
module oppe_divider
    import oppe_pkg::*;
#(
    parameter int CW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [41:0]   i_num,
    input  logic [CW-1:0] i_den,
    output logic          o_done,
    output logic [41:0]   o_quo
);
    localparam int NB = 42;
    localparam logic [5:0] LASTBIT = 6'(NB - 1);

    logic [41:0]   r_quo;
    logic [CW:0]   r_rem;
    logic [5:0]    r_bit;
    logic          r_busy;
    logic          r_done;
    logic [CW:0]   w_sh;
    logic [CW:0]   w_den;

    assign w_den = {1'b0, i_den};
    assign w_sh  = {r_rem[CW-1:0], r_quo[41]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= LASTBIT;
            end else if (r_busy) begin
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_bit <= r_bit - 6'd1;
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            if (w_sh >= w_den) begin
                r_rem <= w_sh - w_den;
                r_quo <= {r_quo[40:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_quo <= {r_quo[40:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== rtl/option_path_payoff_engine_top.sv =====
// Option path payoff engine.
// Input channel: one item per path step (price Q16.16, last_step, clear_totals),
// valid/stall handshake; o_in_stall is high while an item is being worked on.
// Output channel: one item per path end (path payoff, entries, run totals), held
// in an output register until the receiver drops i_out_stall.
// Steps after an accepted item: S_DISC issues the discount product and starts the
// 42-bit restoring divider that forms the running average (one quotient bit per
// cycle), S_DUPD loads the new discount, S_DIV waits on the divider, S_GAIN and
// S_ACC form the discounted payoff, S_FIN accumulates and loads the output register.
// A new item is taken only once the block is back in S_IDLE.
// A waiting result does not block the input; a path end that finds the output
// register full and stalled holds in S_FIN until the receiver takes it.
// Configuration: plain write port, index 0..5 as in the register list; write
// only while idle.
// Reset (synchronous, active low): clears path state, run totals and configuration
// registers; step discount returns to 1.0 in Q1.31.
// A stalled receiver holds the output item; a following path end then waits.
module option_path_payoff_engine_top
    import oppe_pkg::*;
#(
    parameter int MAX_STEPS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam logic [CW-1:0] LIM = CW'(MAX_STEPS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_GAIN = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_DUPD = 3'd6;

    logic        r_kind, r_style;
    logic [2:0]  r_mode;
    logic [31:0] r_strike, r_barrier, r_sdisc;

    logic [2:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [41:0]   r_sum;
    logic [31:0]   r_disc;
    logic          r_crossed;
    logic [41:0]   r_pacc;
    logic [62:0]   r_tot;
    logic [39:0]   r_tent;
    logic [31:0]   r_price;
    logic          r_last;
    logic [31:0]   r_avg;
    logic [41:0]   r_dgain;
    logic          r_ovalid;
    t_out_item     r_out;

    // shared multiplier: operands chosen by state, product registered
    logic [31:0] w_ma, w_mb;
    logic [63:0] r_prod;
    logic [32:0] w_mq;
    logic        w_div_start, w_div_done;
    logic [41:0] w_quo;
    logic [31:0] w_gain;
    logic        w_in_mode, w_out_mode, w_end;
    logic [42:0] w_psum, w_pacc;
    logic [41:0] w_pnew;
    logic [41:0] w_val;
    logic [63:0] w_tsum;
    logic [40:0] w_esum;
    logic [39:0] w_ent;
    logic        w_fin_hold, w_load;

    assign w_in_mode  = (r_mode == MODE_BA_UI) || (r_mode == MODE_BA_DI);
    assign w_out_mode = (r_mode == MODE_BA_UO) || (r_mode == MODE_BA_DO);

    always_comb begin
        case (r_mode)
            MODE_AS_FP: w_gain = r_kind ? ((r_avg > r_price) ? r_avg - r_price : '0)
                                        : ((r_price > r_avg) ? r_price - r_avg : '0);
            MODE_AS_FS: w_gain = r_kind ? ((r_strike > r_avg) ? r_strike - r_avg : '0)
                                        : ((r_avg > r_strike) ? r_avg - r_strike : '0);
            default:    w_gain = r_kind ? ((r_strike > r_price) ? r_strike - r_price : '0)
                                        : ((r_price > r_strike) ? r_price - r_strike : '0);
        endcase
    end

    assign w_ma = (r_state == S_DISC) ? r_disc : w_gain;
    assign w_mb = (r_state == S_DISC) ? r_sdisc : r_disc;
    assign w_mq = r_prod[63:31];

    assign w_div_start = (r_state == S_DISC);

    oppe_divider #(.CW(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_sum),
        .i_den   (r_cnt),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_end  = r_last || (r_cnt >= LIM);
    assign w_pacc = {1'b0, r_pacc} + {1'b0, r_dgain};
    // path accumulator including this step's entry
    assign w_pnew = (r_style == STYLE_AM && (!w_in_mode || r_crossed))
                  ? (w_pacc[42] ? M42 : w_pacc[41:0]) : r_pacc;

    always_comb begin
        if (r_style == STYLE_EU) begin
            if (w_in_mode)       w_val = r_crossed ? r_dgain : '0;
            else if (w_out_mode) w_val = r_crossed ? '0 : r_dgain;
            else                 w_val = r_dgain;
            w_ent = 40'd1;
        end else begin
            w_val = (w_out_mode && r_crossed) ? '0 : w_pnew;
            w_ent = 40'(r_cnt);
        end
    end
    assign w_tsum = {1'b0, r_tot} + {22'd0, w_val};
    assign w_esum = {1'b0, r_tent} + {1'b0, w_ent};
    assign w_psum = {1'b0, r_sum} + {11'd0, i_in_item.price};

    // hold the path end while the previous item still waits under stall
    assign w_fin_hold = w_end && r_ovalid && i_out_stall;
    assign w_load     = (r_state == S_FIN) && w_end && !w_fin_hold;

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= 1'b0; r_style <= STYLE_EU; r_mode <= MODE_PLAIN;
            r_strike <= '0; r_barrier <= '0; r_sdisc <= ONE_Q131;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KIND:    r_kind    <= i_cfg_data[0];
                CFG_STYLE:   r_style   <= i_cfg_data[0];
                CFG_MODE:    r_mode    <= i_cfg_data[2:0];
                CFG_STRIKE:  r_strike  <= i_cfg_data;
                CFG_BARRIER: r_barrier <= i_cfg_data;
                CFG_DISC:    r_sdisc   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_sum <= '0; r_disc <= ONE_Q131;
            r_crossed <= 1'b0; r_pacc <= '0; r_tot <= '0; r_tent <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load)                        r_ovalid <= 1'b1;
            else if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        // take the step: count, sum, barrier check
                        if (i_in_item.clear_totals) begin
                            r_tot <= '0; r_tent <= '0;
                        end
                        r_price <= i_in_item.price;
                        r_last  <= i_in_item.last_step;
                        r_cnt   <= r_cnt + CW'(1);
                        r_sum   <= w_psum[42] ? M42 : w_psum[41:0];
                        if ((r_mode == MODE_BA_UI || r_mode == MODE_BA_UO)
                                && i_in_item.price >= r_barrier)
                            r_crossed <= 1'b1;
                        if ((r_mode == MODE_BA_DI || r_mode == MODE_BA_DO)
                                && i_in_item.price <= r_barrier)
                            r_crossed <= 1'b1;
                        r_state <= S_DISC;
                    end
                end
                S_DISC: r_state <= S_DUPD;
                S_DUPD: begin
                    // discount product is ready: load the new discount
                    r_disc  <= (w_mq[32]) ? '1 : w_mq[31:0];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_avg   <= (w_quo[41:32] != '0) ? '1 : w_quo[31:0];
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: r_state <= S_ACC;
                S_ACC: begin
                    r_dgain <= 42'(r_prod[63:31]);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!w_fin_hold) begin
                        if (w_end) begin
                            r_out.path_payoff   <= w_val;
                            r_out.path_entries  <= 11'(w_ent);
                            r_out.total_payoff  <= w_tsum[63] ? M63 : w_tsum[62:0];
                            r_out.total_entries <= w_esum[40] ? M40 : w_esum[39:0];
                            r_tot  <= w_tsum[63] ? M63 : w_tsum[62:0];
                            r_tent <= w_esum[40] ? M40 : w_esum[39:0];
                            r_cnt <= '0; r_sum <= '0; r_disc <= ONE_Q131;
                            r_crossed <= 1'b0; r_pacc <= '0;
                        end else begin
                            r_pacc <= w_pnew;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;
endmodule

// ===== rtl/oppe_checker.sv =====
module oppe_checker
    import oppe_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed under stall");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("accepted item did not make block busy");

    a_entries_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.path_entries != '0)
        else $error("result with zero entries");
endmodule

bind option_path_payoff_engine_top oppe_checker u_chk (.*);

// ===== test/oppe_checker.sv =====
module oppe_tb_checker
    import oppe_pkg::*;
#(
    parameter int MAX_STEPS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    // configuration copy
    logic        cfg_put;
    logic        cfg_style;
    logic [2:0]  cfg_mode;
    logic [31:0] cfg_strike;
    logic [31:0] cfg_barrier;
    logic [31:0] cfg_disc;

    // path and run state
    logic [10:0] steps;
    logic [41:0] price_sum;
    logic [31:0] disc_now;
    logic        crossed;
    logic [41:0] path_acc;
    logic [62:0] run_total;
    logic [39:0] run_entries;

    t_out_item payoffs_due[$];
    int        fails;

    assign o_fail_count = fails;
    assign o_pending    = payoffs_due.size();

    task automatic clear_path();
        steps     = '0;
        price_sum = '0;
        disc_now  = ONE_Q131;
        crossed   = 1'b0;
        path_acc  = '0;
    endtask

    task automatic take_step(input t_in_item it);
        logic [42:0] s43;
        logic [63:0] prod;
        logic [41:0] avg42;
        logic [31:0] avg;
        logic [31:0] gain;
        logic [63:0] dgain;
        logic [10:0] cnt;
        logic        in_m;
        logic        out_m;
        logic [41:0] val;
        logic [10:0] ent;
        logic [63:0] tot64;
        logic [40:0] ent41;
        t_out_item   r;
        if (it.clear_totals) begin
            run_total   = '0;
            run_entries = '0;
        end
        cnt   = steps + 11'd1;
        steps = cnt;
        s43 = {1'b0, price_sum} + {11'b0, it.price};
        price_sum = s43[42] ? M42 : s43[41:0];
        prod = ({32'b0, disc_now} * {32'b0, cfg_disc}) >> 31;
        disc_now = (prod[63:32] != 0) ? 32'hFFFF_FFFF : prod[31:0];
        if (cfg_mode == MODE_BA_UI || cfg_mode == MODE_BA_UO) begin
            if (it.price >= cfg_barrier) crossed = 1'b1;
        end else if (cfg_mode == MODE_BA_DI || cfg_mode == MODE_BA_DO) begin
            if (it.price <= cfg_barrier) crossed = 1'b1;
        end
        avg42 = price_sum / {31'b0, cnt};
        avg = (avg42[41:32] != 0) ? 32'hFFFF_FFFF : avg42[31:0];
        if (cfg_mode == MODE_AS_FP) begin
            if (cfg_put == KIND_PUT) gain = (avg > it.price) ? avg - it.price : '0;
            else gain = (it.price > avg) ? it.price - avg : '0;
        end else if (cfg_mode == MODE_AS_FS) begin
            if (cfg_put == KIND_PUT) gain = (cfg_strike > avg) ? cfg_strike - avg : '0;
            else gain = (avg > cfg_strike) ? avg - cfg_strike : '0;
        end else begin
            if (cfg_put == KIND_PUT)
                gain = (cfg_strike > it.price) ? cfg_strike - it.price : '0;
            else
                gain = (it.price > cfg_strike) ? it.price - cfg_strike : '0;
        end
        dgain = ({32'b0, gain} * {32'b0, disc_now}) >> 31;
        in_m  = (cfg_mode == MODE_BA_UI || cfg_mode == MODE_BA_DI);
        out_m = (cfg_mode == MODE_BA_UO || cfg_mode == MODE_BA_DO);
        if (cfg_style == STYLE_AM && (!in_m || crossed)) begin
            s43 = {1'b0, path_acc} + {1'b0, dgain[41:0]};
            path_acc = s43[42] ? M42 : s43[41:0];
        end
        if (!(it.last_step || cnt >= MAX_STEPS)) return;
        if (cfg_style == STYLE_EU) begin
            if (in_m) val = crossed ? dgain[41:0] : '0;
            else if (out_m) val = crossed ? '0 : dgain[41:0];
            else val = dgain[41:0];
            ent = 11'd1;
        end else begin
            val = (out_m && crossed) ? '0 : path_acc;
            ent = cnt;
        end
        tot64 = {1'b0, run_total} + {22'b0, val};
        run_total = tot64[63] ? M63 : tot64[62:0];
        ent41 = {1'b0, run_entries} + {30'b0, ent};
        run_entries = ent41[40] ? M40 : ent41[39:0];
        r.path_payoff   = val;
        r.path_entries  = ent;
        r.total_payoff  = run_total;
        r.total_entries = run_entries;
        payoffs_due = {payoffs_due, r};
        clear_path();
    endtask

    task automatic check_payoff(input t_out_item got);
        t_out_item want;
        if (payoffs_due.size() == 0) begin
            $error("unexpected result item %h", got);
            fails++;
            return;
        end
        want = payoffs_due.pop_front();
        if (got.path_payoff !== want.path_payoff) begin
            $error("path_payoff exp %0h got %0h", want.path_payoff, got.path_payoff);
            fails++;
        end
        if (got.path_entries !== want.path_entries) begin
            $error("path_entries exp %0d got %0d", want.path_entries, got.path_entries);
            fails++;
        end
        if (got.total_payoff !== want.total_payoff) begin
            $error("total_payoff exp %0h got %0h", want.total_payoff, got.total_payoff);
            fails++;
        end
        if (got.total_entries !== want.total_entries) begin
            $error("total_entries exp %0d got %0d", want.total_entries, got.total_entries);
            fails++;
        end
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_put     = 1'b0;
            cfg_style   = STYLE_EU;
            cfg_mode    = MODE_PLAIN;
            cfg_strike  = '0;
            cfg_barrier = '0;
            cfg_disc    = ONE_Q131;
            run_total   = '0;
            run_entries = '0;
            clear_path();
            payoffs_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KIND:    cfg_put     = i_cfg_data[0];
                    CFG_STYLE:   cfg_style   = i_cfg_data[0];
                    CFG_MODE:    cfg_mode    = i_cfg_data[2:0];
                    CFG_STRIKE:  cfg_strike  = i_cfg_data;
                    CFG_BARRIER: cfg_barrier = i_cfg_data;
                    CFG_DISC:    cfg_disc    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) take_step(i_in_item);
            if (i_out_valid && !i_out_stall) check_payoff(i_out_item);
        end
    end

endmodule

// ===== test/tb_option_path_payoff_engine_top.sv =====
module tb_option_path_payoff_engine_top;
    import oppe_pkg::*;

    localparam int   MAX_STEPS = 1024;
    localparam logic [2:0] MODE_UNDEF = 3'd7;
    // items may end no path; let the block drain its last one before a write
    localparam int   SETTLE_CYCLES = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int idle_pct  = 0;   // sender gap odds, percent
    int stall_pct = 0;   // receiver stall odds, percent

    always #5 i_clk = ~i_clk;

    option_path_payoff_engine_top #(.MAX_STEPS(MAX_STEPS)) DUT (.*);

    oppe_tb_checker #(.MAX_STEPS(MAX_STEPS)) u_checker (
        .i_clk, .i_rst_n, .i_in_valid,
        .i_in_stall(o_in_stall), .i_in_item,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_item(o_out_item),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: stall at random with the current odds.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Hold valid and item until accepted; insert random gaps first.
    task automatic send_step(input logic [31:0] price, input logic last, input logic clr);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{price: price, last_step: last, clear_totals: clr};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until the block has drained every item.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drive one write; the caller drops the enable after the last one.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic set_option(input logic kind, input logic style, input logic [2:0] mode,
                              input logic [31:0] strike, input logic [31:0] barrier,
                              input logic [31:0] disc);
        wait_idle();
        write_reg(CFG_KIND, {31'b0, kind});
        write_reg(CFG_STYLE, {31'b0, style});
        write_reg(CFG_MODE, {29'b0, mode});
        write_reg(CFG_STRIKE, strike);
        write_reg(CFG_BARRIER, barrier);
        write_reg(CFG_DISC, disc);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly prices near 100.0 so payoffs and barrier hits vary; some full-range.
    function automatic logic [31:0] pick_price();
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return 32'h0050_0000 + $urandom_range(32'h0028_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_disc();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return ONE_Q131;
            3: return $urandom();
            default: return ONE_Q131 - $urandom_range(32'h0100_0000);
        endcase
    endfunction

    // One path of n steps.
    task automatic send_path(input int n);
        for (int s = 1; s <= n; s++)
            send_step(pick_price(), s == n, $urandom_range(19) == 0);
    endtask

    int sent;
    int len;

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every mode, undefined mode, clear totals.
        set_option(KIND_CALL, STYLE_EU, MODE_PLAIN, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_step(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_step(32'h0, 1'b1, 1'b0);
        set_option(KIND_PUT, STYLE_AM, MODE_UNDEF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_step(32'h0, 1'b0, 1'b0);
        send_step(32'h1234_5678, 1'b1, 1'b1);
        for (int m = MODE_AS_FP; m <= MODE_BA_DO; m++) begin
            set_option(m[0], m[1], m[2:0], 32'h0064_0000, 32'h0064_0000, ONE_Q131);
            send_step(32'h0050_0000, 1'b0, 1'b0);
            send_step(32'h0070_0000, 1'b1, 1'b0);
        end

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 83 : (ph == 3) ? 31 : 0;
            stall_pct = (ph == 2) ? 83 : (ph == 3) ? 31 : 0;
            for (int k = 0; k < 6; k++) begin
                set_option(1'($urandom_range(1)), 1'($urandom_range(1)),
                           3'($urandom_range(7)),
                           pick_price(), pick_price(), pick_disc());
                sent = 0;
                while (sent < 16) begin
                    len = $urandom_range(4) == 0 ? $urandom_range(40, 9)
                                                 : $urandom_range(8, 1);
                    send_path(len);
                    sent += len;
                    // pause until every payoff is back once per setting
                    if (sent >= 8 && sent - len < 8) begin
                        i_in_valid <= 1'b0;
                        @(posedge i_clk);
                        wait (pending == 0);
                    end
                end
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("[option_path_payoff_engine_top] OK");
        else
            $display("[option_path_payoff_engine_top] ERROR");
        $finish;
    end

    initial begin
        #20000000;
        $display("[option_path_payoff_engine_top] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/oppe_pkg.sv
rtl/oppe_divider.sv
rtl/option_path_payoff_engine_top.sv
rtl/oppe_checker.sv
test/oppe_checker.sv
test/tb_option_path_payoff_engine_top.sv
